// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define QCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/qct_pkg.sv =====
package qct_pkg;

    // special characters
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // most words one input byte can cause
    localparam int unsigned MAX_WORDS = 3;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_SINGLE = 2'd2
    } mode_t;

    // tokenizer state carried from byte to byte
    typedef struct packed {
        mode_t      mode;
        logic       esc;
        logic [7:0] held_byte;
        logic       held_valid;
    } state_t;

    // one output word
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       tend;
    } word_t;

    // everything one byte produces
    typedef struct packed {
        state_t                      nxt;
        logic [1:0]                  cnt;
        word_t [MAX_WORDS-1:0]       words;
    } step_out_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // characters a backslash may escape in the given mode
    function automatic logic escapable(input logic [7:0] c, input mode_t m);
        logic r;
        r = 1'b0;
        if (c == CH_BSLASH) begin
            r = 1'b1;
        end
        else begin
            case (m)
                MODE_DOUBLE: r = (c == CH_DQUOTE);
                MODE_SINGLE: r = (c == CH_SQUOTE);
                default:     r = (c == CH_DQUOTE) || (c == CH_SQUOTE) || is_ws(c);
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/qct_step.sv =====
module qct_step (
    input  qct_pkg::state_t    cur,
    input  logic [7:0]         ch,
    input  logic               is_final,
    output qct_pkg::step_out_t res
);

    always_comb
    begin
        logic                hv;
        logic [7:0]          hb;
        logic                esc_n;
        logic [1:0]          cnt;
        logic                do_app1;
        logic [7:0]          app1;
        logic                do_app2;
        logic                do_fin_ws;
        qct_pkg::mode_t      m;

        res       = '0;
        hv        = cur.held_valid;
        hb        = cur.held_byte;
        m         = cur.mode;
        esc_n     = 1'b0;
        cnt       = 2'd0;
        do_app1   = 1'b0;
        app1      = ch;
        do_app2   = 1'b0;
        do_fin_ws = 1'b0;

        // pending escape: take the byte, or keep the backslash literally
        if (cur.esc) begin
            do_app1 = 1'b1;
            if (!qct_pkg::escapable(ch, cur.mode)) begin
                app1 = qct_pkg::CH_BSLASH;
            end
        end

        // normal handling of the byte unless it was escaped
        if (!(cur.esc && qct_pkg::escapable(ch, cur.mode))) begin
            if ((ch == qct_pkg::CH_BSLASH) && !is_final) begin
                esc_n = 1'b1;
            end
            else begin
                case (cur.mode)
                    qct_pkg::MODE_DOUBLE:
                    begin
                        if (ch == qct_pkg::CH_DQUOTE) m = qct_pkg::MODE_PLAIN;
                        else                          do_app2 = 1'b1;
                    end
                    qct_pkg::MODE_SINGLE:
                    begin
                        if (ch == qct_pkg::CH_SQUOTE) m = qct_pkg::MODE_PLAIN;
                        else                          do_app2 = 1'b1;
                    end
                    default:
                    begin
                        if (ch == qct_pkg::CH_DQUOTE)      m = qct_pkg::MODE_DOUBLE;
                        else if (ch == qct_pkg::CH_SQUOTE) m = qct_pkg::MODE_SINGLE;
                        else if (qct_pkg::is_ws(ch))       do_fin_ws = 1'b1;
                        else                               do_app2 = 1'b1;
                    end
                endcase
            end
        end

        // first append: the held byte leaves, the new one is held
        if (do_app1) begin
            if (hv) begin
                res.words[cnt] = '{data: hb, valid: 1'b1, tend: 1'b0};
                cnt = cnt + 2'd1;
            end
            hv = 1'b1;
            hb = app1;
        end

        // second append of the byte itself
        if (do_app2) begin
            if (hv) begin
                res.words[cnt] = '{data: hb, valid: 1'b1, tend: 1'b0};
                cnt = cnt + 2'd1;
            end
            hv = 1'b1;
            hb = ch;
        end

        // token closed by unquoted whitespace or by the end of the command
        if (do_fin_ws || is_final) begin
            if (hv) begin
                res.words[cnt] = '{data: hb, valid: 1'b1, tend: 1'b1};
                cnt = cnt + 2'd1;
            end
            hv = 1'b0;
            hb = '0;
        end

        // end of command clears mode and escape, and always yields a word
        if (is_final) begin
            m     = qct_pkg::MODE_PLAIN;
            esc_n = 1'b0;
            if (cnt == 2'd0) begin
                cnt = 2'd1;
            end
        end

        res.cnt            = cnt;
        res.nxt.mode       = m;
        res.nxt.esc        = esc_n;
        res.nxt.held_byte  = hb;
        res.nxt.held_valid = hv;
    end

endmodule

// ===== rtl/quoted_command_tokenizer_core.sv =====
// channel | direction | handshake           | words
// in      | input     | in_valid / in_stall | in_byte, in_final
// out     | output    | out_valid/out_stall | out_byte, byte_valid, token_end,
//         |           |                     | command_end, run_last
//
// an accepted byte waits in the input register until the run register is free,
// then the step logic writes its whole run of 0 to 3 words into the run register in one load
// the run register sends one word per cycle while out_stall is low
// one byte can wait in the input register while a run is stalled at the output
// reset returns to plain mode with nothing held and both registers empty
module quoted_command_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       token_end,
    output logic       command_end,
    output logic       run_last
);

    logic                                   in_valid_reg;
    logic [7:0]                             in_byte_reg;
    logic                                   in_final_reg;
    qct_pkg::state_t                        st_reg;
    qct_pkg::word_t [qct_pkg::MAX_WORDS-1:0] run_words_reg;
    logic [1:0]                             run_cnt_reg;
    logic [1:0]                             run_idx_reg;
    logic                                   run_final_reg;
    qct_pkg::step_out_t                     step;
    qct_pkg::word_t                         cur_word;
    logic                                   run_last_word;
    logic                                   run_free;
    logic                                   load;
    logic                                   take;
    logic                                   pop;

    qct_step u_step (
        .cur      (st_reg),
        .ch       (in_byte_reg),
        .is_final (in_final_reg),
        .res      (step)
    );

    // run register handshake
    assign run_last_word = (run_idx_reg == (run_cnt_reg - 2'd1));
    assign pop           = out_valid && !out_stall;
    assign run_free      = (run_cnt_reg == 2'd0) || (pop && run_last_word);
    assign load          = in_valid_reg && run_free;
    assign in_stall      = in_valid_reg && !run_free;
    assign take          = in_valid && !in_stall;

    // output word selection
    assign cur_word    = run_words_reg[run_idx_reg];
    assign out_valid   = (run_cnt_reg != 2'd0);
    assign out_byte    = cur_word.data;
    assign byte_valid  = cur_word.valid;
    assign token_end   = cur_word.tend;
    assign run_last    = run_last_word;
    assign command_end = run_last_word && run_final_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (take) begin
            in_valid_reg <= 1'b1;
        end
        else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            in_byte_reg  <= in_byte;
            in_final_reg <= in_final;
        end
    end

    // tokenizer state and run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg        <= '{mode: qct_pkg::MODE_PLAIN, esc: 1'b0,
                               held_byte: 8'd0, held_valid: 1'b0};
            run_cnt_reg   <= 2'd0;
            run_idx_reg   <= 2'd0;
            run_final_reg <= 1'b0;
        end
        else if (load) begin
            st_reg        <= step.nxt;
            run_cnt_reg   <= step.cnt;
            run_idx_reg   <= 2'd0;
            run_final_reg <= in_final_reg;
        end
        else if (pop) begin
            if (run_last_word) begin
                run_cnt_reg <= 2'd0;
            end
            else begin
                run_idx_reg <= run_idx_reg + 2'd1;
            end
        end
    end

    // run words
    always_ff @(posedge clk)
    begin
        if (load) begin
            run_words_reg <= step.words;
        end
    end

endmodule

// ===== rtl/qct_checker.sv =====
`include "assert_macros.svh"

module qct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       in_final,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       token_end,
    input logic       command_end,
    input logic       run_last
);

    // a stalled input word holds until it is taken
    `QCT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(in_byte) && $stable(in_final))

    // a word with no character is the bare end-of-command marker
    `QCT_ASSERT_SAME(a_empty_word, clk, rst_n, out_valid && !byte_valid,
        !token_end && (out_byte == 8'd0) && command_end)

    // the end of a command closes the run of its byte
    `QCT_ASSERT_SAME(a_cmd_end_last, clk, rst_n, out_valid && command_end, run_last)

    // a character at the end of a command always closes its token
    `QCT_ASSERT_SAME(a_cmd_end_token, clk, rst_n, out_valid && command_end && byte_valid,
        token_end)

    // a stalled output word holds
    `QCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(token_end)
        && $stable(command_end) && $stable(run_last))

endmodule

bind quoted_command_tokenizer_core qct_checker u_qct_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // one word as seen on the out channel
    typedef struct packed {
        logic [7:0] chr;
        logic       chr_ok;
        logic       tok_end;
        logic       cmd_end;
        logic       run_end;
    } tok_word_t;

    // one directed byte, with a typed-in word where it is obvious
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       typed;
        tok_word_t  want;
    } plan_row_t;

    localparam int unsigned PLAN_ROWS   = 27;
    localparam int unsigned RAND_BYTES  = 180;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned MAX_SHOWN   = 40;
    localparam tok_word_t   BARE_END    = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_final;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       command_end;
    logic       run_last;

    // tokenizer state as predicted
    qct_pkg::mode_t tok_mode;
    logic           esc_wait;
    logic [7:0]     held_chr;
    logic           held_ok;

    // words caused by the byte just accepted
    tok_word_t  run_words [3];
    int unsigned run_cnt;

    tok_word_t  expected_words [$];
    plan_row_t  plan [PLAN_ROWS];

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned commands_sent;
    int unsigned words_seen;
    bit          calm;
    bit          holding;

    quoted_command_tokenizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_final    (in_final),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .token_end   (token_end),
        .command_end (command_end),
        .run_last    (run_last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // hard limit on the whole run
    initial
    begin
        #400000;
        $display("timeout: run did not finish in time");
        $display("quoted_command_tokenizer_core test failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= MAX_SHOWN)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    // space, tab, LF, VT, FF and CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // what a backslash may escape in the current quote mode
    function automatic logic can_escape(input logic [7:0] c);
        logic ok;
        if (c == qct_pkg::CH_BSLASH)
        begin
            ok = 1'b1;
        end
        else if (tok_mode == qct_pkg::MODE_DOUBLE)
        begin
            ok = (c == qct_pkg::CH_DQUOTE);
        end
        else if (tok_mode == qct_pkg::MODE_SINGLE)
        begin
            ok = (c == qct_pkg::CH_SQUOTE);
        end
        else
        begin
            ok = (c == qct_pkg::CH_DQUOTE) || (c == qct_pkg::CH_SQUOTE) || is_blank(c);
        end
        return ok;
    endfunction

    task automatic emit_word(input tok_word_t w);
        run_words[run_cnt] = w;
        run_cnt++;
    endtask

    // the previous held byte goes out, the new one is held back
    task automatic add_char(input logic [7:0] c);
        if (held_ok)
        begin
            emit_word('{held_chr, 1'b1, 1'b0, 1'b0, 1'b0});
        end
        held_chr = c;
        held_ok  = 1'b1;
    endtask

    task automatic close_token();
        if (held_ok)
        begin
            emit_word('{held_chr, 1'b1, 1'b1, 1'b0, 1'b0});
        end
        held_ok  = 1'b0;
        held_chr = 8'h00;
    endtask

    // one character with no escape waiting
    task automatic scan_char(input logic [7:0] c, input logic f);
        if ((c == qct_pkg::CH_BSLASH) && !f)
        begin
            esc_wait = 1'b1;
        end
        else if (tok_mode == qct_pkg::MODE_DOUBLE)
        begin
            if (c == qct_pkg::CH_DQUOTE)
                tok_mode = qct_pkg::MODE_PLAIN;
            else
                add_char(c);
        end
        else if (tok_mode == qct_pkg::MODE_SINGLE)
        begin
            if (c == qct_pkg::CH_SQUOTE)
                tok_mode = qct_pkg::MODE_PLAIN;
            else
                add_char(c);
        end
        else if (c == qct_pkg::CH_DQUOTE)
        begin
            tok_mode = qct_pkg::MODE_DOUBLE;
        end
        else if (c == qct_pkg::CH_SQUOTE)
        begin
            tok_mode = qct_pkg::MODE_SINGLE;
        end
        else if (is_blank(c))
        begin
            close_token();
        end
        else
        begin
            add_char(c);
        end
    endtask

    // predicted words for one accepted byte
    task automatic tokenize_byte(input logic [7:0] c, input logic f);
        run_cnt = 0;
        if (esc_wait)
        begin
            esc_wait = 1'b0;
            if (can_escape(c))
            begin
                add_char(c);
            end
            else
            begin
                add_char(qct_pkg::CH_BSLASH);
                scan_char(c, f);
            end
        end
        else
        begin
            scan_char(c, f);
        end
        // end of command flushes the token and clears quote and escape
        if (f)
        begin
            close_token();
            tok_mode = qct_pkg::MODE_PLAIN;
            esc_wait = 1'b0;
            if (run_cnt == 0)
            begin
                emit_word('0);
            end
            run_words[run_cnt-1].cmd_end = 1'b1;
        end
        if (run_cnt > 0)
        begin
            run_words[run_cnt-1].run_end = 1'b1;
        end
    endtask

    // mostly shell-like characters, some arbitrary bytes
    function automatic logic [7:0] pick_char();
        int unsigned roll;
        logic [7:0]  c;
        roll = $urandom_range(99);
        if (roll < 35)
            c = 8'($urandom_range(8'h7A, 8'h61));
        else if (roll < 42)
            c = qct_pkg::CH_SPACE;
        else if (roll < 50)
            c = 8'($urandom_range(8'h0D, 8'h08));
        else if (roll < 62)
            c = qct_pkg::CH_DQUOTE;
        else if (roll < 72)
            c = qct_pkg::CH_SQUOTE;
        else if (roll < 84)
            c = qct_pkg::CH_BSLASH;
        else
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // offer one byte, wait for it to be taken, then predict
    task automatic push_byte(input logic [7:0] c, input logic f, input logic typed,
                             input tok_word_t want);
        int unsigned k;
        while (!calm && !holding && ($urandom_range(99) < 29))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_final <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tokenize_byte(c, f);
        if (typed)
        begin
            expected_words = {expected_words, want};
        end
        else
        begin
            for (k = 0; k < run_cnt; k++)
            begin
                expected_words = {expected_words, run_words[k]};
            end
        end
        bytes_sent++;
        if (f)
        begin
            commands_sent++;
        end
    endtask

    // out channel: check each word taken, stall at random, one long hold
    initial
    begin : drain
        tok_word_t   got;
        tok_word_t   want;
        int unsigned hold_left;
        bit          hold_done;
        out_stall <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{out_byte, byte_valid, token_end, command_end, run_last};
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word byte %h v%b e%b c%b l%b",
                        got.chr, got.chr_ok, got.tok_end, got.cmd_end, got.run_end));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if ((got.chr !== want.chr) || (got.chr_ok !== want.chr_ok) ||
                        (got.tok_end !== want.tok_end) || (got.cmd_end !== want.cmd_end) ||
                        (got.run_end !== want.run_end))
                    begin
                        flag_mismatch($sformatf(
                            "word %0d: got %h v%b e%b c%b l%b, want %h v%b e%b c%b l%b",
                            words_seen, got.chr, got.chr_ok, got.tok_end, got.cmd_end,
                            got.run_end, want.chr, want.chr_ok, want.tok_end,
                            want.cmd_end, want.run_end));
                    end
                end
            end
            // long hold so the block fills up and stalls its input
            if (!hold_done && (words_seen >= 60))
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                holding   = 1'b1;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                holding = 1'b0;
                out_stall <= !calm && ($urandom_range(99) < 29);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned i;
        int unsigned len;
        int unsigned sent_rand;
        int unsigned guard;
        logic [7:0]  c;
        logic        noisy;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_final <= 1'b0;
        tok_mode = qct_pkg::MODE_PLAIN;
        esc_wait = 1'b0;
        held_chr = 8'h00;
        held_ok  = 1'b0;
        run_cnt  = 0;
        calm     = 1'b0;
        holding  = 1'b0;

        // lone final bytes from a clean state
        plan[0]  = '{8'h20,              1'b1, 1'b1, BARE_END};
        plan[1]  = '{8'hFF,              1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}};
        plan[2]  = '{qct_pkg::CH_BSLASH, 1'b1, 1'b1,
                     '{qct_pkg::CH_BSLASH, 1'b1, 1'b1, 1'b1, 1'b1}};
        plan[3]  = '{qct_pkg::CH_DQUOTE, 1'b1, 1'b1, BARE_END};
        // whitespace boundaries in plain mode
        plan[4]  = '{8'h00,              1'b0, 1'b0, '0};
        plan[5]  = '{8'h08,              1'b0, 1'b0, '0};
        plan[6]  = '{8'h09,              1'b0, 1'b0, '0};
        plan[7]  = '{8'h0E,              1'b0, 1'b0, '0};
        plan[8]  = '{8'h0A,              1'b0, 1'b0, '0};
        // double quotes: space kept, escaped quote, backslash before other
        plan[9]  = '{qct_pkg::CH_DQUOTE, 1'b0, 1'b0, '0};
        plan[10] = '{qct_pkg::CH_SPACE,  1'b0, 1'b0, '0};
        plan[11] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[12] = '{qct_pkg::CH_DQUOTE, 1'b0, 1'b0, '0};
        plan[13] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[14] = '{qct_pkg::CH_SQUOTE, 1'b0, 1'b0, '0};
        plan[15] = '{qct_pkg::CH_DQUOTE, 1'b0, 1'b0, '0};
        // single quotes, left open to the end of the command
        plan[16] = '{qct_pkg::CH_SQUOTE, 1'b0, 1'b0, '0};
        plan[17] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[18] = '{qct_pkg::CH_SQUOTE, 1'b0, 1'b0, '0};
        plan[19] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[20] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[21] = '{8'h0C,              1'b0, 1'b0, '0};
        plan[22] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[23] = '{8'h7A,              1'b1, 1'b0, '0};
        // escaped whitespace in plain mode, then a final CR
        plan[24] = '{qct_pkg::CH_BSLASH, 1'b0, 1'b0, '0};
        plan[25] = '{8'h0B,              1'b0, 1'b0, '0};
        plan[26] = '{qct_pkg::CH_CR,     1'b1, 1'b0, '0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            push_byte(plan[i].chr, plan[i].last, plan[i].typed, plan[i].want);
        end

        // random commands, a few of pure noise and a few long ones
        sent_rand = 0;
        while (sent_rand < RAND_BYTES)
        begin
            calm  = (sent_rand >= 120) && (sent_rand < 170);
            len   = ($urandom_range(7) == 0) ? $urandom_range(30, 12) : $urandom_range(10, 1);
            noisy = ($urandom_range(9) == 0);
            for (i = 1; i <= len; i++)
            begin
                c = noisy ? 8'($urandom_range(255)) : pick_char();
                push_byte(c, i == len, 1'b0, '0);
                sent_rand++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then give stray words a chance to show up
        guard = 0;
        while ((expected_words.size() != 0) && (guard < 20000))
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected words never arrived",
                expected_words.size()));
        end

        $display("covered %0d bytes in %0d commands, %0d words checked, %0d mismatches",
            bytes_sent, commands_sent, words_seen, errors);
        $display("quoting, escapes, unclosed quotes and a long output hold were exercised");
        if (errors == 0)
        begin
            $display("quoted_command_tokenizer_core test passed");
        end
        else
        begin
            $display("quoted_command_tokenizer_core test failed");
        end
        $finish;
    end

endmodule
